// ===== hdl/clr_pkg.sv =====
// ============================================================================
// clr_pkg - shared types and constants of the clipped line rasteriser
// Command, job and pixel transaction types and the stepper state encoding.
// ============================================================================
package clr_pkg;

    localparam int COORD_BITS = 12;
    localparam int PIX_BITS   = 6;
    localparam int COLOR_BITS = 32;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_row;
        logic signed [COORD_BITS-1:0] start_col;
        logic signed [COORD_BITS-1:0] end_row;
        logic signed [COORD_BITS-1:0] end_col;
        logic [COLOR_BITS-1:0]        line_color;
    } t_cmd;

    typedef struct packed {
        logic [PIX_BITS-1:0]   pixel_col;
        logic [PIX_BITS-1:0]   pixel_row;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  is_last;
    } t_pixel;

    typedef struct packed {
        logic                         steep;
        logic                         step_neg;
        logic signed [COORD_BITS-1:0] maj0;
        logic signed [COORD_BITS-1:0] maj1;
        logic signed [COORD_BITS-1:0] min0;
        logic [COORD_BITS-1:0]        dmaj;
        logic [COORD_BITS-1:0]        dmin;
        logic [COLOR_BITS-1:0]        color;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } t_back_state;

endpackage

// ===== hdl/clr_front.sv =====
// ============================================================================
// clr_front - line command classifier
// Pick the major axis, order the endpoints and form the extents of a line.
// ============================================================================
module clr_front import clr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_cmd i_cmd,
    output logic o_in_stall,
    output logic o_job_valid,
    output t_job o_job,
    input  logic i_job_stall
);

    logic signed [COORD_BITS:0] d_row;
    logic signed [COORD_BITS:0] d_col;
    logic signed [COORD_BITS:0] m_row;
    logic signed [COORD_BITS:0] m_col;
    logic [COORD_BITS-1:0]      a_row;
    logic [COORD_BITS-1:0]      a_col;
    logic                       steep;
    logic                       swap;
    logic                       min_neg;
    t_job                       job;
    logic                       r_job_valid;
    t_job                       r_job;

    always_comb begin
        d_row = (COORD_BITS+1)'(i_cmd.end_row) - (COORD_BITS+1)'(i_cmd.start_row);
        d_col = (COORD_BITS+1)'(i_cmd.end_col) - (COORD_BITS+1)'(i_cmd.start_col);
        m_row = d_row[COORD_BITS] ? -d_row : d_row;
        m_col = d_col[COORD_BITS] ? -d_col : d_col;
        a_row = m_row[COORD_BITS-1:0];
        a_col = m_col[COORD_BITS-1:0];
        steep   = a_row > a_col;
        swap    = steep ? d_row[COORD_BITS] : d_col[COORD_BITS];
        min_neg = steep ? d_col[COORD_BITS] : d_row[COORD_BITS];

        job.steep    = steep;
        job.step_neg = min_neg ^ swap;
        job.dmaj     = steep ? a_row : a_col;
        job.dmin     = steep ? a_col : a_row;
        job.color    = i_cmd.line_color;
        if (steep) begin
            job.maj0 = swap ? i_cmd.end_row   : i_cmd.start_row;
            job.maj1 = swap ? i_cmd.start_row : i_cmd.end_row;
            job.min0 = swap ? i_cmd.end_col   : i_cmd.start_col;
        end else begin
            job.maj0 = swap ? i_cmd.end_col   : i_cmd.start_col;
            job.maj1 = swap ? i_cmd.start_col : i_cmd.end_col;
            job.min0 = swap ? i_cmd.end_row   : i_cmd.start_row;
        end
    end

    assign o_in_stall = r_job_valid && i_job_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_job_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_job <= job;
        end
    end

    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

endmodule

// ===== hdl/clr_queue.sv =====
// ============================================================================
// clr_queue - two-entry job queue
// Decouple the classifier from the stepper so that each stalls on its own.
// ============================================================================
module clr_queue import clr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_job i_push_job,
    output logic o_push_stall,
    output logic o_pop_valid,
    output t_job o_pop_job,
    input  logic i_pop
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_push_stall = r_count == 2'd2;
    assign o_pop_valid  = r_count != 2'd0;
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && !o_push_stall;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

// ===== hdl/clr_back.sv =====
// ============================================================================
// clr_back - line stepper
// Step along the major axis one pixel a cycle unless stalled, drop off-screen
// pixels and mark the last kept pixel through a one-pixel hold register.
// ============================================================================
module clr_back import clr_pkg::*; #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_job_valid,
    input  t_job   i_job,
    output logic   o_pop,
    output logic   o_out_valid,
    output t_pixel o_pixel,
    input  logic   i_out_stall
);

    localparam logic signed [COORD_BITS-1:0] ROW_LIM = COORD_BITS'(SCREEN_HEIGHT);
    localparam logic signed [COORD_BITS-1:0] COL_LIM = COORD_BITS'(SCREEN_WIDTH);
    localparam logic signed [COORD_BITS-1:0] ROW_MAX = COORD_BITS'(SCREEN_HEIGHT - 1);
    localparam logic signed [COORD_BITS-1:0] COL_MAX = COORD_BITS'(SCREEN_WIDTH - 1);

    t_back_state                  r_state;
    t_back_state                  n_state;
    logic signed [COORD_BITS-1:0] r_mj;
    logic signed [COORD_BITS-1:0] r_mn;
    logic [COORD_BITS:0]          r_err;
    t_job                         r_job;
    logic                         r_pend_valid;
    t_pixel                       r_pend;
    logic                         r_out_valid;
    t_pixel                       r_out;

    logic signed [COORD_BITS-1:0] row;
    logic signed [COORD_BITS-1:0] col;
    logic                         inb;
    logic                         at_end;
    logic [COORD_BITS:0]          err_sum;
    logic                         minor_move;
    logic                         out_free;
    logic                         load;
    logic                         run_go;
    logic                         push_run;
    logic                         push_last;

    always_comb begin
        row = r_job.steep ? r_mj : r_mn;
        col = r_job.steep ? r_mn : r_mj;
        inb = (row >= 0) && (row < ROW_LIM) && (col >= 0) && (col < COL_LIM);
        at_end = (r_mj == r_job.maj1) ||
                 (r_mj >= (r_job.steep ? ROW_MAX : COL_MAX));
        err_sum    = r_err + {1'b0, r_job.dmin};
        minor_move = err_sum > {1'b0, r_job.dmaj};
        out_free   = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (run_go && at_end) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_pend_valid || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        load      = 1'b0;
        run_go    = 1'b0;
        push_run  = 1'b0;
        push_last = 1'b0;
        case (r_state)
            ST_IDLE: begin
                load = i_job_valid;
            end
            ST_RUN: begin
                run_go   = out_free || !(inb && r_pend_valid);
                push_run = run_go && inb && r_pend_valid;
            end
            ST_FLUSH: begin
                push_last = r_pend_valid && out_free;
            end
            default: begin
                load = 1'b0;
            end
        endcase
    end

    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (run_go && inb) begin
                r_pend_valid <= 1'b1;
            end else if (push_last) begin
                r_pend_valid <= 1'b0;
            end
            if (push_run || push_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
            r_mj  <= i_job.maj0;
            r_mn  <= i_job.min0;
            r_err <= {2'b00, i_job.dmaj[COORD_BITS-1:1]};
        end else if (run_go) begin
            r_mj <= r_mj + COORD_BITS'(1);
            if (minor_move) begin
                r_err <= err_sum - {1'b0, r_job.dmaj};
                r_mn  <= r_job.step_neg ? r_mn - COORD_BITS'(1) : r_mn + COORD_BITS'(1);
            end else begin
                r_err <= err_sum;
            end
        end
        if (run_go && inb) begin
            r_pend.pixel_col   <= col[PIX_BITS-1:0];
            r_pend.pixel_row   <= row[PIX_BITS-1:0];
            r_pend.pixel_color <= r_job.color;
            r_pend.is_last     <= 1'b0;
        end
        if (push_run) begin
            r_out <= r_pend;
        end else if (push_last) begin
            r_out <= '{pixel_col:   r_pend.pixel_col,
                       pixel_row:   r_pend.pixel_row,
                       pixel_color: r_pend.pixel_color,
                       is_last:     1'b1};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel     = r_out;

endmodule

// ===== hdl/clipped_line_rasterizer.sv =====
// ============================================================================
// clipped_line_rasterizer - clipped line drawing engine
// Turns line commands into the on-screen pixels of each line.
// ============================================================================
// Input channel: i_in_valid / i_cmd / o_in_stall carries one line command per
// transaction (two signed endpoints and a colour). Output channel:
// o_out_valid / o_pixel / i_out_stall carries one on-screen pixel per
// transaction, in stepping order, with is_last set on the final one. A line
// that lies wholly off screen gives no pixel transactions.
// A command is registered by the classifier and queued (two entries). The
// stepper takes one job at a time and visits one major-axis position per
// cycle unless the output stalls, from the lower major endpoint to the upper
// one, stopping early at the last major coordinate on the screen. Each pixel
// is held one step so that the last one can be marked. After reset both
// channels are empty. A stall on the output holds the stepper, then the
// queue, then the input.
// ============================================================================
module clipped_line_rasterizer import clr_pkg::*; #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  t_cmd   i_cmd,
    output logic   o_in_stall,
    output logic   o_out_valid,
    output t_pixel o_pixel,
    input  logic   i_out_stall
);

    logic f_valid;
    t_job f_job;
    logic f_stall;
    logic q_valid;
    t_job q_job;
    logic q_pop;

    clr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cmd       (i_cmd),
        .o_in_stall  (o_in_stall),
        .o_job_valid (f_valid),
        .o_job       (f_job),
        .i_job_stall (f_stall)
    );

    clr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .i_push_job   (f_job),
        .o_push_stall (f_stall),
        .o_pop_valid  (q_valid),
        .o_pop_job    (q_job),
        .i_pop        (q_pop)
    );

    clr_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_pixel     (o_pixel),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== tb/testbench.sv =====
// ============================================================================
// testbench - self-checking bench for the clipped line rasteriser
// Sends line commands through the command channel and checks every pixel
// transaction against a stepping model of the line kept in the bench. It
// starts with a directed set (points, corners, diagonals, clipped and fully
// off-screen lines, extreme coordinates), then random lines mostly near the
// screen. The random part runs under three idle mixes on the two channels.
// ============================================================================
module testbench import clr_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCREEN_W    = 64;
    localparam int SCREEN_H    = 64;
    localparam int PIXEL_CAP   = 64;
    localparam int QUIET_LIMIT = 20000;
    localparam int TAIL_CYCLES = 4200;
    localparam int RANDOM_PER_MIX = 146;

    typedef struct {
        t_cmd cmd;
        int   send_idle;
        int   recv_idle;
        bit   drain;
    } queued_line_t;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_in_valid = 1'b0;
    t_cmd   i_cmd = '0;
    logic   o_in_stall;
    logic   o_out_valid;
    t_pixel o_pixel;
    logic   i_out_stall = 1'b0;

    queued_line_t line_queue[$];
    t_pixel       expected_pixels[$];
    queued_line_t pending;
    t_pixel       next_pixel;

    int fill_send_idle = 31;
    int fill_recv_idle = 78;
    int send_idle_pct = 31;
    int recv_idle_pct = 78;

    int n_commands = 0;
    int n_blank_lines = 0;
    int n_pixels = 0;
    int n_errors = 0;
    int quiet_cycles = 0;

    // stepping position left behind by the last line
    logic [COORD_BITS-1:0] walk_major_pos = '0;
    logic [COORD_BITS-1:0] walk_minor_pos = '0;
    logic [12:0]           walk_error = '0;
    logic [COORD_BITS-1:0] walk_major_end = '0;
    logic                  walk_step_neg = 1'b0;
    logic                  walk_steep = 1'b0;
    logic [COLOR_BITS-1:0] walk_color = '0;

    clipped_line_rasterizer #(
        .SCREEN_WIDTH (SCREEN_W),
        .SCREEN_HEIGHT(SCREEN_H)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_pixel    (o_pixel),
        .i_out_stall(i_out_stall)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void predict_line(input t_cmd cmd);
        int r0, c0, r1, c1, dr, dc;
        int maj0, maj1, min0, min1, dmaj, dmin, stp, err, mn, row, col, tmp, n;
        bit steep, held;
        t_pixel prev;
        r0 = int'($signed(cmd.start_row));
        c0 = int'($signed(cmd.start_col));
        r1 = int'($signed(cmd.end_row));
        c1 = int'($signed(cmd.end_col));
        dr = r1 - r0;
        if (dr < 0) dr = -dr;
        dc = c1 - c0;
        if (dc < 0) dc = -dc;
        steep = dr > dc;
        if (steep) begin
            maj0 = r0; maj1 = r1; min0 = c0; min1 = c1;
        end else begin
            maj0 = c0; maj1 = c1; min0 = r0; min1 = r1;
        end
        if (maj1 < maj0) begin
            tmp = maj0; maj0 = maj1; maj1 = tmp;
            tmp = min0; min0 = min1; min1 = tmp;
        end
        dmaj = maj1 - maj0;
        dmin = min1 - min0;
        stp = 1;
        if (dmin < 0) begin
            dmin = -dmin;
            stp = -1;
        end
        err = dmaj / 2;
        mn = min0;
        n = 0;
        held = 1'b0;
        prev = '0;
        for (int mj = maj0; mj <= maj1; mj++) begin
            row = steep ? mj : mn;
            col = steep ? mn : mj;
            if (row >= 0 && row < SCREEN_H && col >= 0 && col < SCREEN_W && n < PIXEL_CAP) begin
                if (held) expected_pixels.push_back(prev);
                prev.pixel_col   = col[PIX_BITS-1:0];
                prev.pixel_row   = row[PIX_BITS-1:0];
                prev.pixel_color = cmd.line_color;
                prev.is_last     = 1'b0;
                held = 1'b1;
                n++;
            end
            err += dmin;
            if (err > dmaj) begin
                err -= dmaj;
                mn += stp;
            end
        end
        if (held) begin
            prev.is_last = 1'b1;
            expected_pixels.push_back(prev);
        end else begin
            n_blank_lines++;
        end
        walk_major_pos = maj1[COORD_BITS-1:0];
        walk_minor_pos = mn[COORD_BITS-1:0];
        walk_error     = err[12:0];
        walk_major_end = maj1[COORD_BITS-1:0];
        walk_step_neg  = stp < 0;
        walk_steep     = steep;
        walk_color     = cmd.line_color;
    endfunction

    function automatic void add_line(input int r0, input int c0, input int r1, input int c1,
                                     input logic [COLOR_BITS-1:0] color, input bit drain);
        queued_line_t item;
        item.cmd.start_row  = r0[COORD_BITS-1:0];
        item.cmd.start_col  = c0[COORD_BITS-1:0];
        item.cmd.end_row    = r1[COORD_BITS-1:0];
        item.cmd.end_col    = c1[COORD_BITS-1:0];
        item.cmd.line_color = color;
        item.send_idle      = fill_send_idle;
        item.recv_idle      = fill_recv_idle;
        item.drain          = drain;
        line_queue.push_back(item);
    endfunction

    function automatic int pick(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // command driver: predict on acceptance, then present the next line
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_line(i_cmd);
                n_commands++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (line_queue.size() == 0 ||
                    (line_queue[0].drain && expected_pixels.size() != 0) ||
                    $urandom_range(0, 99) < send_idle_pct) begin
                    i_in_valid <= 1'b0;
                end else begin
                    pending = line_queue.pop_front();
                    send_idle_pct <= pending.send_idle;
                    recv_idle_pct <= pending.recv_idle;
                    i_cmd <= pending.cmd;
                    i_in_valid <= 1'b1;
                end
            end
        end
    end

    // pixel monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_pixels++;
                if (expected_pixels.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("%0t: unexpected pixel col=%0d row=%0d color=%h last=%0b",
                                 $time, o_pixel.pixel_col, o_pixel.pixel_row,
                                 o_pixel.pixel_color, o_pixel.is_last);
                end else begin
                    next_pixel = expected_pixels.pop_front();
                    if (o_pixel.pixel_col !== next_pixel.pixel_col ||
                        o_pixel.pixel_row !== next_pixel.pixel_row ||
                        o_pixel.pixel_color !== next_pixel.pixel_color ||
                        o_pixel.is_last !== next_pixel.is_last) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display({"%0t: pixel mismatch: expected col=%0d row=%0d color=%h ",
                                      "last=%0b, got col=%0d row=%0d color=%h last=%0b"},
                                     $time, next_pixel.pixel_col, next_pixel.pixel_row,
                                     next_pixel.pixel_color, next_pixel.is_last,
                                     o_pixel.pixel_col, o_pixel.pixel_row,
                                     o_pixel.pixel_color, o_pixel.is_last);
                    end
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d pixels outstanding",
                     quiet_cycles, expected_pixels.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int kind, r0, c0, r1, c1;
        add_line(0, 0, 0, 0, 32'h0000_0000, 1'b0);
        add_line(63, 63, 63, 63, 32'hFFFF_FFFF, 1'b0);
        add_line(-1, 5, -1, 5, 32'h1234_5678, 1'b0);
        add_line(5, 64, 5, 64, 32'h8765_4321, 1'b0);
        add_line(0, 0, 63, 63, 32'hFF00_FF00, 1'b0);
        add_line(63, 0, 0, 63, 32'h00FF_00FF, 1'b0);
        add_line(0, -100, 0, 200, 32'hAAAA_5555, 1'b0);
        add_line(300, 63, -300, 63, 32'h5555_AAAA, 1'b0);
        add_line(40, 10, 2, 30, 32'hDEAD_BEEF, 1'b0);
        add_line(10, 2, 14, 60, 32'hCAFE_F00D, 1'b0);
        add_line(-2048, -2048, 2047, 2047, 32'h8000_0001, 1'b0);
        add_line(2047, 2047, -2048, -2048, 32'h7FFF_FFFE, 1'b0);
        add_line(-2048, -2048, -2048, 2047, 32'h0F0F_0F0F, 1'b1);
        add_line(70, 0, 70, 63, 32'hF0F0_F0F0, 1'b0);
        add_line(10, 10, 2047, 30, 32'h0123_4567, 1'b0);
        add_line(-2048, 2047, 2047, -2048, 32'h89AB_CDEF, 1'b0);
        add_line(-5, -5, 70, 70, 32'h3C3C_C3C3, 1'b0);
        add_line(32, -2000, 40, 2000, 32'hC3C3_3C3C, 1'b0);
        add_line(0, 63, 63, 0, 32'h1111_2222, 1'b0);
        add_line(20, 20, 21, 60, 32'h3333_4444, 1'b0);
        add_line(-1, -1, 64, 64, 32'h5555_6666, 1'b0);
        add_line(2047, 0, 2047, 63, 32'h7777_8888, 1'b0);

        for (int mix = 0; mix < 3; mix++) begin
            fill_send_idle = (mix == 0) ? 31 : (mix == 1) ? 78 : 0;
            fill_recv_idle = (mix == 0) ? 78 : (mix == 1) ? 31 : 0;
            for (int i = 0; i < RANDOM_PER_MIX; i++) begin
                kind = $urandom_range(0, 99);
                if (kind < 60) begin
                    r0 = pick(-12, 75); c0 = pick(-12, 75);
                    r1 = pick(-12, 75); c1 = pick(-12, 75);
                end else if (kind < 70) begin
                    r0 = pick(0, 63); c0 = pick(0, 63);
                    r1 = r0 + pick(-3, 3); c1 = c0 + pick(-3, 3);
                end else if (kind < 78) begin
                    r0 = pick(-4, 67); c0 = pick(-12, 75);
                    r1 = r0; c1 = pick(-12, 75);
                    if ($urandom_range(0, 1)) begin
                        {r0, c0} = {c0, r0};
                        {r1, c1} = {c1, r1};
                    end
                end else if (kind < 88) begin
                    r0 = pick(0, 63); c0 = pick(0, 63);
                    r1 = pick(-2048, 2047); c1 = pick(-2048, 2047);
                    if ($urandom_range(0, 1)) begin
                        {r0, r1} = {r1, r0};
                        {c0, c1} = {c1, c0};
                    end
                end else begin
                    r0 = pick(-2048, 2047); c0 = pick(-2048, 2047);
                    r1 = pick(-2048, 2047); c1 = pick(-2048, 2047);
                end
                add_line(r0, c0, r1, c1, $urandom, (i % 50) == 49);
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (line_queue.size() != 0 || i_in_valid || expected_pixels.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d line commands sent (%0d with no on-screen pixel), %0d pixels checked",
                 n_commands, n_blank_lines, n_pixels);
        $display("idle mixes: sender-light/receiver-heavy, reversed, none; %0d mismatches",
                 n_errors);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
